// ===== rtl/swsr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swsr_pkg
// Types and constants shared by the single-wire sensor reader modules.
// ----------------------------------------------------------------------------
package swsr_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int FRAME_BITS  = 40;
    localparam int BIT_IDX_W   = 6;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_START_LOW    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ACK_TIMEOUT  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_THRESH   = 2'd3;

    localparam logic [15:0] START_LOW_RESET    = 16'd18000;
    localparam logic [15:0] RELEASE_HIGH_RESET = 16'd40;
    localparam logic [15:0] ACK_TIMEOUT_RESET  = 16'd100;
    localparam logic [7:0]  ONE_THRESH_RESET   = 8'd40;

    localparam logic [7:0] HIGH_TIME_MAX = 8'd255;

    // line drive codes
    localparam logic [1:0] DRIVE_RELEASED = 2'd0;
    localparam logic [1:0] DRIVE_LOW      = 2'd1;
    localparam logic [1:0] DRIVE_HIGH     = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_ACK_TIMEOUT = 2'd1;
    localparam logic [1:0] STATUS_CHECKSUM    = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_START_LOW  = 4'd1,
        PH_START_HIGH = 4'd2,
        PH_ACK_LOW    = 4'd3,
        PH_ACK_HIGH   = 4'd4,
        PH_BIT_LOW    = 4'd5,
        PH_BIT_HIGH   = 4'd6
    } t_phase;

    typedef struct packed {
        logic [15:0] start_low_ticks;
        logic [15:0] release_high_ticks;
        logic [15:0] ack_timeout_ticks;
        logic [7:0]  one_threshold_ticks;
    } t_cfg;

    typedef struct packed {
        logic command;
        logic line_level;
    } t_in_item;

    typedef struct packed {
        logic [1:0] line_drive;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] temperature;
        logic [7:0] humidity;
    } t_out_item;

endpackage
`default_nettype wire

// ===== rtl/swsr_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swsr_core
// Transaction sequencer: start pulse, acknowledge phases, bit timing,
// frame shift and checksum. State advances once per accepted tick.
// ----------------------------------------------------------------------------
module swsr_core #(
    parameter int TICK_COUNTER_WIDTH = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_accept,
    input  swsr_pkg::t_cfg        i_cfg,
    input  swsr_pkg::t_in_item    i_item,
    output swsr_pkg::t_out_item   o_result
);

    localparam int TW    = TICK_COUNTER_WIDTH;
    localparam int CMP_W = (TW > swsr_pkg::CFG_DATA_W) ? TW : swsr_pkg::CFG_DATA_W;

    swsr_pkg::t_phase                  r_phase, n_phase;
    logic [TW-1:0]                     r_tick, n_tick;
    logic [swsr_pkg::BIT_IDX_W-1:0]    r_bit_index, n_bit_index;
    logic [swsr_pkg::FRAME_BITS-1:0]   r_frame, n_frame;
    logic [1:0]                        r_status, n_status;
    logic [7:0]                        r_temp, n_temp;
    logic [7:0]                        r_hum, n_hum;
    logic                              n_done;

    logic [swsr_pkg::BIT_IDX_W-1:0]    bit_index_inc;
    logic [swsr_pkg::FRAME_BITS-1:0]   frame_shifted;
    logic [7:0]                        byte_sum;
    logic                              tick_full;
    logic                              start_low_hit;
    logic                              release_hit;
    logic                              ack_hit;
    logic                              pulse_is_one;

    assign tick_full     = &r_tick;
    assign start_low_hit = (CMP_W'(r_tick) >= CMP_W'(i_cfg.start_low_ticks)) || tick_full;
    assign release_hit   = (CMP_W'(r_tick) >= CMP_W'(i_cfg.release_high_ticks)) || tick_full;
    assign ack_hit       = (CMP_W'(r_tick) >= CMP_W'(i_cfg.ack_timeout_ticks)) || tick_full;
    assign pulse_is_one  = r_tick > TW'(i_cfg.one_threshold_ticks);
    assign bit_index_inc = r_bit_index + 1'b1;
    assign frame_shifted = {r_frame[swsr_pkg::FRAME_BITS-2:0], pulse_is_one};
    assign byte_sum      = frame_shifted[39:32] + frame_shifted[31:24]
                         + frame_shifted[23:16] + frame_shifted[15:8];

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_bit_index = r_bit_index;
        n_frame     = r_frame;
        n_status    = r_status;
        n_temp      = r_temp;
        n_hum       = r_hum;
        n_done      = 1'b0;
        case (r_phase)
            swsr_pkg::PH_START_LOW: begin
                if (start_low_hit) begin
                    n_phase = swsr_pkg::PH_START_HIGH;
                    n_tick  = '0;
                end else begin
                    n_tick = r_tick + 1'b1;
                end
            end
            swsr_pkg::PH_START_HIGH: begin
                if (release_hit) begin
                    n_phase = swsr_pkg::PH_ACK_LOW;
                    n_tick  = '0;
                end else begin
                    n_tick = r_tick + 1'b1;
                end
            end
            swsr_pkg::PH_ACK_LOW: begin
                if (i_item.line_level) begin
                    n_phase = swsr_pkg::PH_ACK_HIGH;
                    n_tick  = '0;
                end else if (ack_hit) begin
                    n_status = swsr_pkg::STATUS_ACK_TIMEOUT;
                    n_done   = 1'b1;
                    n_phase  = swsr_pkg::PH_IDLE;
                end else begin
                    n_tick = r_tick + 1'b1;
                end
            end
            swsr_pkg::PH_ACK_HIGH: begin
                if (!i_item.line_level) begin
                    n_phase     = swsr_pkg::PH_BIT_LOW;
                    n_bit_index = '0;
                    n_frame     = '0;
                end else if (ack_hit) begin
                    n_status = swsr_pkg::STATUS_ACK_TIMEOUT;
                    n_done   = 1'b1;
                    n_phase  = swsr_pkg::PH_IDLE;
                end else begin
                    n_tick = r_tick + 1'b1;
                end
            end
            swsr_pkg::PH_BIT_LOW: begin
                if (i_item.line_level) begin
                    n_phase = swsr_pkg::PH_BIT_HIGH;
                    n_tick  = TW'(1);
                end
            end
            swsr_pkg::PH_BIT_HIGH: begin
                if (i_item.line_level) begin
                    // high time saturates
                    if (r_tick < TW'(swsr_pkg::HIGH_TIME_MAX)) begin
                        n_tick = r_tick + 1'b1;
                    end
                end else begin
                    n_frame     = frame_shifted;
                    n_bit_index = bit_index_inc;
                    if (bit_index_inc >= swsr_pkg::BIT_IDX_W'(swsr_pkg::FRAME_BITS)) begin
                        n_done  = 1'b1;
                        n_phase = swsr_pkg::PH_IDLE;
                        if (byte_sum == frame_shifted[7:0]) begin
                            n_status = swsr_pkg::STATUS_OK;
                            n_temp   = frame_shifted[23:16];
                            n_hum    = frame_shifted[39:32];
                        end else begin
                            n_status = swsr_pkg::STATUS_CHECKSUM;
                        end
                    end else begin
                        n_phase = swsr_pkg::PH_BIT_LOW;
                    end
                end
            end
            default: begin
                n_phase = swsr_pkg::PH_IDLE;
                if (i_item.command) begin
                    n_phase = swsr_pkg::PH_START_LOW;
                    n_tick  = '0;
                end
            end
        endcase
    end

    // result fields follow the state after this tick
    always_comb begin
        case (n_phase)
            swsr_pkg::PH_START_LOW:  o_result.line_drive = swsr_pkg::DRIVE_LOW;
            swsr_pkg::PH_START_HIGH: o_result.line_drive = swsr_pkg::DRIVE_HIGH;
            default:                 o_result.line_drive = swsr_pkg::DRIVE_RELEASED;
        endcase
        o_result.busy_res    = (n_phase != swsr_pkg::PH_IDLE);
        o_result.done_res    = n_done;
        o_result.status      = n_status;
        o_result.temperature = n_temp;
        o_result.humidity    = n_hum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= swsr_pkg::PH_IDLE;
            r_tick      <= '0;
            r_bit_index <= '0;
            r_frame     <= '0;
            r_status    <= swsr_pkg::STATUS_OK;
            r_temp      <= '0;
            r_hum       <= '0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_bit_index <= n_bit_index;
            r_frame     <= n_frame;
            r_status    <= n_status;
            r_temp      <= n_temp;
            r_hum       <= n_hum;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/single_wire_sensor_reader.sv =====
`default_nettype none
// An accepted item's result is registered in the output register.
// Throughput: one item per cycle while results are taken; the output register
// takes a new result in the same cycle that the previous one is taken.
// Reset (synchronous, active low): sequencer idle, counters and held values zero,
// configuration registers at their default timings, no result pending.
// ----------------------------------------------------------------------------
// single_wire_sensor_reader
// Single-wire humidity/temperature sensor reader, one item per microsecond tick.
// ----------------------------------------------------------------------------
module single_wire_sensor_reader #(
    parameter int TICK_COUNTER_WIDTH = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire  [swsr_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  wire  [swsr_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  swsr_pkg::t_in_item                    i_in_item,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output swsr_pkg::t_out_item                   o_out_item
);

    swsr_pkg::t_cfg      r_cfg;
    swsr_pkg::t_out_item core_result;
    swsr_pkg::t_out_item r_out_item;
    logic                r_out_valid;
    logic                accept;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_low_ticks     <= swsr_pkg::START_LOW_RESET;
            r_cfg.release_high_ticks  <= swsr_pkg::RELEASE_HIGH_RESET;
            r_cfg.ack_timeout_ticks   <= swsr_pkg::ACK_TIMEOUT_RESET;
            r_cfg.one_threshold_ticks <= swsr_pkg::ONE_THRESH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                swsr_pkg::REG_START_LOW:    r_cfg.start_low_ticks    <= i_cfg_data;
                swsr_pkg::REG_RELEASE_HIGH: r_cfg.release_high_ticks <= i_cfg_data;
                swsr_pkg::REG_ACK_TIMEOUT:  r_cfg.ack_timeout_ticks  <= i_cfg_data;
                swsr_pkg::REG_ONE_THRESH:   r_cfg.one_threshold_ticks <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    swsr_core #(
        .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cfg    (r_cfg),
        .i_item   (i_in_item),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_item <= core_result;
        end
    end

`ifndef NO_ASSERTIONS
    // every accepted item leaves a result behind
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted item gave no result");

    // a finished transaction returns to idle
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.done_res) |-> !r_out_item.busy_res)
        else $error("done reported while still busy");

    // the line is only driven inside a transaction
    a_drive_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_item.line_drive != swsr_pkg::DRIVE_RELEASED))
            |-> r_out_item.busy_res)
        else $error("line driven outside a transaction");

    // the held humidity reading only changes when a transaction finishes cleanly
    a_held_change_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_out_valid && (core_result.humidity != r_out_item.humidity))
            |-> (core_result.done_res && (core_result.status == swsr_pkg::STATUS_OK)))
        else $error("held humidity changed without a good frame");
`endif

endmodule
`default_nettype wire
